@@ hw/rtl/cra_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cra_pkg: shared definitions for the contiguous ring allocator
// Field widths, operation and status codes, and the readable-block helpers.
// ----------------------------------------------------------------------------
package cra_pkg;

    localparam int INDEX_BITS = 15;
    localparam int OP_BITS    = 2;
    localparam int STAT_BITS  = 2;

    localparam logic [INDEX_BITS-1:0] RING_SIZE_RESET = '1;

    typedef logic [INDEX_BITS-1:0] idx_t;
    typedef logic [INDEX_BITS:0]   idx_sum_t;

    typedef enum logic [OP_BITS-1:0] {
        OP_RESERVE = 2'd0,
        OP_COMMIT  = 2'd1,
        OP_CONSUME = 2'd2
    } op_t;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_NO_RESV   = 2'd2,
        ST_OVER_READ = 2'd3
    } status_t;

    typedef struct packed {
        idx_t start;
        idx_t length;
    } rd_block_t;

    function automatic idx_t sub_floor(input idx_t a, input idx_t b);
        return (a > b) ? idx_t'(a - b) : '0;
    endfunction

    // Contiguous readable block for a given ring state
    function automatic rd_block_t readable(input logic empty, input idx_t rd,
                                           input idx_t wr, input logic gap,
                                           input idx_t gap_size, input idx_t size);
        rd_block_t blk;
        idx_t      gap_pos;
        blk     = '0;
        gap_pos = sub_floor(size, gap_size);
        if (!empty) begin
            blk.start = rd;
            if (rd < wr) begin
                blk.length = idx_t'(wr - rd);
            end else if (!gap) begin
                blk.length = sub_floor(size, rd);
            end else if (rd == gap_pos) begin
                blk.start  = '0;
                blk.length = wr;
            end else begin
                blk.length = sub_floor(gap_pos, rd);
            end
        end
        return blk;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/contiguous_ring_allocator_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_ring_allocator_core: bip-buffer style region allocator
// Hands out contiguous regions of a ring and reports the readable block.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one beat is an operation (s_op: reserve, commit,
//   consume) and a slot count. Result channel m_*: one beat per input beat,
//   carrying status, granted offset, the contiguous readable block after the
//   operation and the empty flag.
//   Config channel cfg_*: writes the ring size and re-initializes the ring;
//   write it only while no beat is in flight. cfg_ready is always high.
//   Path: an accepted input beat passes through the input register, then
//   the result register. Throughput is one beat per cycle while m_ready
//   is high; the ring state is updated in the same cycle that loads the
//   result register, so back-to-back beats see each other's effects.
//   Reset: ring size returns to 32767, ring is empty, no reservation pending,
//   both channels are empty. Reset is synchronous, active low.
//   Stall: when m_ready is low the result is held; the input register fills
//   once more and then s_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module contiguous_ring_allocator_core (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [cra_pkg::INDEX_BITS-1:0]     cfg_data,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  [cra_pkg::OP_BITS-1:0]        s_op,
    input  wire  [cra_pkg::INDEX_BITS-1:0]     s_count,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [cra_pkg::STAT_BITS-1:0]      m_status,
    output logic [cra_pkg::INDEX_BITS-1:0]     m_grant_offset,
    output logic [cra_pkg::INDEX_BITS-1:0]     m_read_offset,
    output logic [cra_pkg::INDEX_BITS-1:0]     m_read_length,
    output logic                               m_ring_empty
);
    import cra_pkg::*;

    // input register
    logic                 in_vld_reg;
    logic [OP_BITS-1:0]   op_reg;
    idx_t                 count_reg;

    // ring state
    idx_t size_reg;
    idx_t rd_reg,   rd_next;
    idx_t wr_reg,   wr_next;
    logic empty_reg, empty_next;
    logic gap_reg,  gap_next;
    idx_t gap_size_reg, gap_size_next;
    idx_t pend_cnt_reg, pend_cnt_next;
    idx_t pend_pos_reg, pend_pos_next;

    // result register
    logic                 out_vld_reg;
    logic [STAT_BITS-1:0] status_reg, status_next;
    idx_t                 grant_reg, grant_next;
    idx_t                 rd_off_reg, rd_len_reg;
    logic                 out_empty_reg;

    logic      advance;
    logic      fire;
    logic      cfg_wr;
    rd_block_t cur_blk;
    rd_block_t new_blk;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;
    assign advance   = !out_vld_reg || m_ready;
    assign s_ready   = !in_vld_reg || advance;
    assign fire      = in_vld_reg && advance;

    assign cur_blk = readable(empty_reg, rd_reg, wr_reg, gap_reg, gap_size_reg, size_reg);
    assign new_blk = readable(empty_next, rd_next, wr_next, gap_next, gap_size_next,
                              size_reg);

    always_comb begin
        logic     fits;
        idx_t     pos;
        idx_t     tail;
        idx_t     gap_pos;
        idx_sum_t nw;
        rd_next       = rd_reg;
        wr_next       = wr_reg;
        empty_next    = empty_reg;
        gap_next      = gap_reg;
        gap_size_next = gap_size_reg;
        pend_cnt_next = pend_cnt_reg;
        pend_pos_next = pend_pos_reg;
        status_next   = ST_OK;
        grant_next    = '0;
        fits          = 1'b1;
        pos           = wr_reg;
        tail          = sub_floor(size_reg, wr_reg);
        gap_pos       = sub_floor(size_reg, gap_size_reg);
        nw            = '0;
        unique case (op_reg)
            OP_RESERVE: begin
                if (empty_reg) begin
                    pos  = '0;
                    fits = count_reg <= size_reg;
                end else if (rd_reg < wr_reg) begin
                    if (count_reg <= tail) begin
                        pos = wr_reg;
                    end else if (count_reg <= rd_reg) begin
                        pos = '0;
                    end else begin
                        fits = 1'b0;
                    end
                end else begin
                    fits = count_reg <= idx_t'(rd_reg - wr_reg);
                end
                if (fits) begin
                    pend_cnt_next = count_reg;
                    pend_pos_next = pos;
                    grant_next    = pos;
                end else begin
                    status_next = ST_NO_FIT;
                end
            end
            OP_COMMIT: begin
                if (pend_cnt_reg == '0) begin
                    status_next = ST_NO_RESV;
                end else begin
                    if (empty_reg) begin
                        rd_next       = pend_pos_reg;
                        nw            = {1'b0, pend_pos_reg} + {1'b0, pend_cnt_reg};
                        wr_next       = (nw == {1'b0, size_reg}) ? '0 : nw[INDEX_BITS-1:0];
                        gap_next      = 1'b0;
                        gap_size_next = '0;
                    end else if (rd_reg < wr_reg) begin
                        if (pend_cnt_reg > tail) begin
                            // wrap to slot 0 and leave the tail as a gap
                            gap_size_next = tail;
                            gap_next      = 1'b1;
                            wr_next       = pend_cnt_reg;
                        end else begin
                            nw      = {1'b0, wr_reg} + {1'b0, pend_cnt_reg};
                            wr_next = (nw == {1'b0, size_reg}) ? '0 : nw[INDEX_BITS-1:0];
                        end
                    end else begin
                        wr_next = idx_t'(wr_reg + pend_cnt_reg);
                    end
                    empty_next    = 1'b0;
                    pend_cnt_next = '0;
                end
            end
            OP_CONSUME: begin
                if (count_reg > cur_blk.length) begin
                    status_next = ST_OVER_READ;
                end else if (!empty_reg) begin
                    if (gap_reg) begin
                        if (rd_reg == gap_pos) begin
                            // skip the gap: read restarts at slot 0
                            rd_next       = count_reg;
                            gap_next      = 1'b0;
                            gap_size_next = '0;
                            if (wr_reg == count_reg) begin
                                empty_next = 1'b1;
                            end
                        end else begin
                            rd_next = idx_t'(rd_reg + count_reg);
                        end
                    end else if (rd_reg < wr_reg) begin
                        if (count_reg == cur_blk.length) begin
                            empty_next = 1'b1;
                        end
                        rd_next = idx_t'(rd_reg + count_reg);
                    end else if (count_reg == sub_floor(size_reg, rd_reg)) begin
                        rd_next = '0;
                        if (wr_reg == '0) begin
                            empty_next = 1'b1;
                        end
                    end else begin
                        rd_next = idx_t'(rd_reg + count_reg);
                    end
                end
            end
            default: begin
                // unused op code: no change
            end
        endcase
    end

    // handshake and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    // ring state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg     <= RING_SIZE_RESET;
            rd_reg       <= '0;
            wr_reg       <= '0;
            empty_reg    <= 1'b1;
            gap_reg      <= 1'b0;
            gap_size_reg <= '0;
            pend_cnt_reg <= '0;
            pend_pos_reg <= '0;
        end else if (cfg_wr) begin
            size_reg     <= cfg_data;
            rd_reg       <= '0;
            wr_reg       <= '0;
            empty_reg    <= 1'b1;
            gap_reg      <= 1'b0;
            gap_size_reg <= '0;
            pend_cnt_reg <= '0;
            pend_pos_reg <= '0;
        end else if (fire) begin
            rd_reg       <= rd_next;
            wr_reg       <= wr_next;
            empty_reg    <= empty_next;
            gap_reg      <= gap_next;
            gap_size_reg <= gap_size_next;
            pend_cnt_reg <= pend_cnt_next;
            pend_pos_reg <= pend_pos_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready) begin
            op_reg    <= s_op;
            count_reg <= s_count;
        end
        if (fire) begin
            status_reg    <= status_next;
            grant_reg     <= grant_next;
            rd_off_reg    <= new_blk.start;
            rd_len_reg    <= new_blk.length;
            out_empty_reg <= empty_next;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_status       = status_reg;
    assign m_grant_offset = grant_reg;
    assign m_read_offset  = rd_off_reg;
    assign m_read_length  = rd_len_reg;
    assign m_ring_empty   = out_empty_reg;

    // a gap only exists while data is held
    a_gap_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        gap_reg |-> !empty_reg)
        else $error("gap flag set on an empty ring");

    // an empty ring reports no readable block
    a_empty_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ring_empty) |-> (m_read_length == '0 && m_read_offset == '0))
        else $error("empty ring reports a readable block");

    // every commit clears the pending reservation
    a_commit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && op_reg == OP_COMMIT) |=> (pend_cnt_reg == '0))
        else $error("reservation still pending after commit");

    // a waiting input beat stays put while the result side is stalled
    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(op_reg) && $stable(count_reg)))
        else $error("input register lost a stalled beat");

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for contiguous_ring_allocator_core
// Drives reserve, commit, consume and unused-op beats under several ring sizes and idle
// patterns. Every accepted beat runs through a behavioral ring model, and each
// result beat is checked field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_top;
    import cra_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;
    localparam int COUNT_MAX   = 32767;

    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        idx_t size;
        idx_t rd;
        idx_t wr;
        logic empty;
        logic gap;
        idx_t gap_len;
        idx_t resv_len;
        idx_t resv_pos;
    } ring_state_t;

    typedef struct packed {
        logic [STAT_BITS-1:0] status;
        idx_t                 grant;
        idx_t                 rd_off;
        idx_t                 rd_len;
        logic                 empty;
    } alloc_result_t;

    typedef struct packed {
        ring_state_t   st;
        alloc_result_t res;
    } ring_step_t;

    typedef struct packed {
        idx_t start;
        idx_t len;
    } span_t;

    typedef struct packed {
        logic [OP_BITS-1:0] op;
        idx_t               count;
    } alloc_req_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [INDEX_BITS-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [OP_BITS-1:0]    s_op      = '0;
    logic [INDEX_BITS-1:0] s_count   = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [STAT_BITS-1:0]  m_status;
    logic [INDEX_BITS-1:0] m_grant_offset;
    logic [INDEX_BITS-1:0] m_read_offset;
    logic [INDEX_BITS-1:0] m_read_length;
    logic                  m_ring_empty;

    alloc_req_t    op_backlog[$];
    alloc_result_t alloc_expected[$];

    ring_state_t   ring_model;
    ring_state_t   ring_plan;
    alloc_result_t plan_last;
    ring_step_t    model_step;
    alloc_req_t    next_req;
    alloc_result_t got;
    alloc_result_t want;

    bit item_held      = 1'b0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_trig      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;

    always #6 aclk = ~aclk;

    contiguous_ring_allocator_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_count        (s_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_grant_offset (m_grant_offset),
        .m_read_offset  (m_read_offset),
        .m_read_length  (m_read_length),
        .m_ring_empty   (m_ring_empty)
    );

    function automatic idx_t floor_diff(input idx_t a, input idx_t b);
        return (a > b) ? idx_t'(a - b) : '0;
    endfunction

    function automatic ring_state_t ring_cleared(input idx_t size);
        ring_state_t st;
        st       = '0;
        st.size  = size;
        st.empty = 1'b1;
        return st;
    endfunction

    function automatic span_t readable_span(input ring_state_t st);
        span_t sp;
        idx_t  gap_at;
        sp     = '0;
        gap_at = floor_diff(st.size, st.gap_len);
        if (!st.empty) begin
            sp.start = st.rd;
            if (st.rd < st.wr) begin
                sp.len = idx_t'(st.wr - st.rd);
            end else if (!st.gap) begin
                sp.len = floor_diff(st.size, st.rd);
            end else if (st.rd == gap_at) begin
                // read pointer sits at the gap: data resumes at slot 0
                sp.start = '0;
                sp.len   = st.wr;
            end else begin
                sp.len = floor_diff(gap_at, st.rd);
            end
        end
        return sp;
    endfunction

    function automatic ring_step_t ring_advance(input ring_state_t st,
                                                input logic [OP_BITS-1:0] op,
                                                input idx_t cnt);
        ring_step_t r;
        span_t      sp;
        idx_t       pos;
        idx_t       room;
        idx_t       gap_at;
        idx_sum_t   nw;
        logic       fits;
        r        = '0;
        r.st     = st;
        r.res.status = ST_OK;
        case (op)
            OP_RESERVE: begin
                fits = 1'b1;
                pos  = st.wr;
                if (st.empty) begin
                    pos  = '0;
                    fits = (cnt <= st.size);
                end else if (st.rd < st.wr) begin
                    if (cnt <= floor_diff(st.size, st.wr)) begin
                        pos = st.wr;
                    end else if (cnt <= st.rd) begin
                        pos = '0;
                    end else begin
                        fits = 1'b0;
                    end
                end else begin
                    fits = (cnt <= idx_t'(st.rd - st.wr));
                end
                if (fits) begin
                    r.st.resv_len = cnt;
                    r.st.resv_pos = pos;
                    r.res.grant   = pos;
                end else begin
                    r.res.status = ST_NO_FIT;
                end
            end
            OP_COMMIT: begin
                if (st.resv_len == '0) begin
                    r.res.status = ST_NO_RESV;
                end else begin
                    if (st.empty) begin
                        r.st.rd      = st.resv_pos;
                        nw           = {1'b0, st.resv_pos} + {1'b0, st.resv_len};
                        r.st.wr      = (nw == {1'b0, st.size}) ? '0 : nw[INDEX_BITS-1:0];
                        r.st.gap     = 1'b0;
                        r.st.gap_len = '0;
                    end else if (st.rd < st.wr) begin
                        room = floor_diff(st.size, st.wr);
                        if (st.resv_len > room) begin
                            // wrapped region: leave the tail unused
                            r.st.gap_len = room;
                            r.st.gap     = 1'b1;
                            r.st.wr      = st.resv_len;
                        end else begin
                            nw      = {1'b0, st.wr} + {1'b0, st.resv_len};
                            r.st.wr = (nw == {1'b0, st.size}) ? '0 : nw[INDEX_BITS-1:0];
                        end
                    end else begin
                        r.st.wr = idx_t'(st.wr + st.resv_len);
                    end
                    r.st.empty    = 1'b0;
                    r.st.resv_len = '0;
                end
            end
            OP_CONSUME: begin
                sp = readable_span(st);
                if (cnt > sp.len) begin
                    r.res.status = ST_OVER_READ;
                end else if (!st.empty) begin
                    if (st.gap) begin
                        gap_at = floor_diff(st.size, st.gap_len);
                        if (st.rd == gap_at) begin
                            r.st.rd      = cnt;
                            r.st.gap     = 1'b0;
                            r.st.gap_len = '0;
                            if (st.wr == cnt) r.st.empty = 1'b1;
                        end else begin
                            r.st.rd = idx_t'(st.rd + cnt);
                        end
                    end else if (st.rd < st.wr) begin
                        if (cnt == sp.len) r.st.empty = 1'b1;
                        r.st.rd = idx_t'(st.rd + cnt);
                    end else if (cnt == floor_diff(st.size, st.rd)) begin
                        r.st.rd = '0;
                        if (st.wr == '0) r.st.empty = 1'b1;
                    end else begin
                        r.st.rd = idx_t'(st.rd + cnt);
                    end
                end
            end
            default: begin
            end
        endcase
        sp           = readable_span(r.st);
        r.res.rd_off = sp.start;
        r.res.rd_len = sp.len;
        r.res.empty  = r.st.empty;
        return r;
    endfunction

    function automatic idx_t reserve_len(input idx_t size);
        case ($urandom_range(0, 3))
            0:       return idx_t'($urandom_range(0, (int'(size) >> 3) + 1));
            1:       return idx_t'($urandom_range(0, int'(size) >> 1));
            2:       return idx_t'($urandom_range(0, int'(size)));
            default: return size;
        endcase
    endfunction

    // Queue one beat and advance the planning copy so later beats can track it
    task automatic push_req(input logic [OP_BITS-1:0] op, input idx_t count);
        ring_step_t nx;
        alloc_req_t rq;
        nx        = ring_advance(ring_plan, op, count);
        ring_plan = nx.st;
        plan_last = nx.res;
        rq.op     = op;
        rq.count  = count;
        op_backlog.push_back(rq);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (op_backlog.size() != 0 || item_held || alloc_expected.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_ring_size(input idx_t value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        ring_plan       = ring_cleared(value);
        plan_last       = '0;
        plan_last.empty = 1'b1;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input idx_t size, input int n_items, input int send_pct,
                                input int recv_pct, input bit pressure);
        int   pick;
        int   len;
        idx_t cnt;
        write_ring_size(size);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (pressure) hold_trig++;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            len  = int'(plan_last.rd_len);
            if (pick < 35) begin
                push_req(OP_RESERVE, reserve_len(size));
                if ($urandom_range(0, 3) != 0)
                    push_req(OP_COMMIT, idx_t'($urandom_range(0, COUNT_MAX)));
            end else if (pick < 70) begin
                cnt = idx_t'($urandom_range(0, len));
                if ($urandom_range(0, 3) == 0) cnt = idx_t'(len);
                push_req(OP_CONSUME, cnt);
            end else if (pick < 80) begin
                push_req(OP_COMMIT, idx_t'($urandom_range(0, COUNT_MAX)));
            end else if (pick < 90) begin
                if ($urandom_range(0, 1) != 0)
                    push_req(OP_CONSUME, idx_t'((len < COUNT_MAX) ? len + 1 : len));
                else
                    push_req(OP_RESERVE, idx_t'((size < COUNT_MAX) ? int'(size) + 1
                                                                   : COUNT_MAX));
            end else begin
                push_req(OP_BITS'($urandom_range(0, 2)),
                         idx_t'($urandom_range(0, COUNT_MAX)));
            end
        end
    endtask

    // Sender: present a new beat only once the previous one has been taken
    always @(negedge aclk) begin
        if (!item_held) begin
            if (aresetn && op_backlog.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                next_req  = op_backlog.pop_front();
                s_valid  <= 1'b1;
                s_op     <= next_req.op;
                s_count  <= next_req.count;
                item_held = 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: long hold when requested, random stalls otherwise
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready  <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_seen != hold_trig) begin
            hold_seen = hold_trig;
            hold_left = HOLD_CYCLES;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Predict on every accepted input beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            ring_model = ring_cleared(RING_SIZE_RESET);
        end else begin
            if (cfg_valid && cfg_ready) ring_model = ring_cleared(cfg_data);
            if (s_valid && s_ready && item_held) begin
                model_step = ring_advance(ring_model, s_op, s_count);
                ring_model = model_step.st;
                alloc_expected.push_back(model_step.res);
                item_held = 1'b0;
            end
        end
    end

    // Check result beats and watch for a hung handshake
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got.status = m_status;
            got.grant  = m_grant_offset;
            got.rd_off = m_read_offset;
            got.rd_len = m_read_length;
            got.empty  = m_ring_empty;
            if (alloc_expected.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display({"unexpected result beat: status %0d grant %0d rd %0d",
                              " len %0d empty %0b"},
                             got.status, got.grant, got.rd_off, got.rd_len, got.empty);
            end else begin
                want = alloc_expected.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"mismatch: status %0d/%0d grant %0d/%0d rd %0d/%0d",
                                  " len %0d/%0d empty %0b/%0b (exp/act)"},
                                 want.status, got.status, want.grant, got.grant,
                                 want.rd_off, got.rd_off, want.rd_len, got.rd_len,
                                 want.empty, got.empty);
                end
            end
        end
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[contiguous_ring_allocator_core] ERROR");
            $finish;
        end
    end

    initial begin
        ring_plan       = ring_cleared(RING_SIZE_RESET);
        plan_last       = '0;
        plan_last.empty = 1'b1;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // reset size: empty-ring cases, zero reserve, oversized requests
        push_req(OP_CONSUME, '0);
        push_req(OP_COMMIT, '0);
        push_req(OP_RESERVE, '0);
        push_req(OP_COMMIT, '1);
        push_req(OP_RESERVE, '1);
        push_req(OP_RESERVE, 15'd10);
        push_req(OP_COMMIT, '0);
        push_req(OP_RESERVE, '1);
        push_req(OP_CONSUME, 15'd11);
        push_req(OP_CONSUME, 15'd10);
        push_req(OP_UNUSED, 15'h5555);

        // fill completely, then drain across the end of the ring
        write_ring_size(15'd8);
        push_req(OP_RESERVE, 15'd8);
        push_req(OP_COMMIT, '0);
        push_req(OP_RESERVE, '0);
        push_req(OP_RESERVE, 15'd1);
        push_req(OP_CONSUME, 15'd3);
        push_req(OP_CONSUME, 15'd5);

        // wrapped commit leaving a gap, zero consume at the gap
        push_req(OP_RESERVE, 15'd6);
        push_req(OP_COMMIT, '0);
        push_req(OP_CONSUME, 15'd4);
        push_req(OP_RESERVE, 15'd3);
        push_req(OP_COMMIT, '0);
        push_req(OP_CONSUME, 15'd2);
        push_req(OP_CONSUME, '0);
        push_req(OP_CONSUME, 15'd3);

        write_ring_size('0);
        push_req(OP_RESERVE, '0);
        push_req(OP_RESERVE, 15'd1);
        push_req(OP_COMMIT, '0);
        push_req(OP_CONSUME, '0);

        random_phase(15'd32767, 160, 0, 0, 1'b0);
        random_phase(15'd64, 160, 54, 0, 1'b0);
        random_phase(15'd13, 160, 0, 54, 1'b0);
        random_phase(15'd1, 120, 24, 24, 1'b0);
        random_phase(15'd300, 200, 0, 0, 1'b1);
        random_phase(15'd32767, 160, 0, 54, 1'b0);
        random_phase(idx_t'($urandom_range(2, 40)), 150, 24, 24, 1'b0);

        wait_idle();
        repeat (8) @(posedge aclk);
        if (error_count == 0 && alloc_expected.size() == 0) begin
            $display("[contiguous_ring_allocator_core] OK");
        end else begin
            $display("[contiguous_ring_allocator_core] ERROR");
        end
        $finish;
    end

endmodule
